// ===== rtl/pcrc_pkg.sv =====
// ============================================================================
// pcrc_pkg: shared types and constants for the page CRC32c deframer/checker
// Holds the transfer payload structs, status and register codes and the
// byte-wide CRC32c update function.
// ============================================================================
package pcrc_pkg;

    // Input item: one byte of the framed stream.
    typedef struct packed {
        logic [7:0]         framed_byte;
        logic signed [63:0] start_offset;
        logic               last;
    } t_in_item;

    // Result item: one per input byte.
    typedef struct packed {
        logic               data_valid;
        logic [7:0]         data_byte;
        logic               page_done;
        logic               page_bad;
        logic signed [63:0] page_offset;
        logic [12:0]        page_length;
        logic [1:0]         status;
        logic [31:0]        bytes_delivered;
        logic [7:0]         bad_pages;
        logic               end_of_transaction;
    } t_out_item;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLLECT_MODE    = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_BAD_PAGE_LIMIT  = 2'd2;

    // Sticky status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CRC_FATAL = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    // Each record opens with this many big-endian CRC bytes.
    localparam logic [2:0] CRC_BYTES = 3'd4;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    localparam logic [31:0] CAPACITY_RESET  = 32'hFFFF_FFFF;
    localparam logic [7:0]  BAD_LIMIT_RESET = 8'd16;

    // Reflected CRC32c update over one byte, LSB first.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/page_crc32c_deframer_checker.sv =====
// ============================================================================
// page_crc32c_deframer_checker: per-page CRC32c deframer and checker
// Strips the 4-byte CRC that heads each file page of a framed byte stream,
// passes the data bytes on, checks every page and reports its offset, length
// and status.
// ============================================================================
//
//  Channel  | Ports                                  | Direction | Payload
//  ---------+----------------------------------------+-----------+-----------------------
//  input    | i_in_valid, o_in_stall, i_in_data      | in        | pcrc_pkg::t_in_item
//  output   | o_out_valid, i_out_stall, o_out_data   | out       | pcrc_pkg::t_out_item
//  config   | i_cfg_we, i_cfg_index, i_cfg_data      | in        | 32-bit register write
//
// The block takes one byte per cycle while o_in_stall is low and returns one
// result per byte. The whole per-byte step (CRC32c update, page boundary
// test, capacity and overflow checks) is one combinational pass from the
// state registers into the result register, or into the skid register.
// A skid register behind the result register lets a byte be taken while the
// previous result is still stalled; o_in_stall rises only when both are full.
// Reset is synchronous and active low; it clears the control state and sets
// the configuration registers to their defaults.
// PAGE_SIZE must be a power of two, so a page boundary is the low address
// bits of the offset rolling over.
//
module page_crc32c_deframer_checker #(
    parameter int PAGE_SIZE = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pcrc_pkg::t_in_item   i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pcrc_pkg::t_out_item  o_out_data,

    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PAGE_BITS = $clog2(PAGE_SIZE);
    localparam int CNT_W     = $clog2(PAGE_SIZE + 1);

    // Configuration registers.
    logic        r_collect_mode;
    logic [31:0] r_capacity;
    logic [7:0]  r_bad_limit;

    // Transaction state.
    logic              r_in_txn;
    logic [2:0]        r_phase;
    logic [31:0]       r_exp_crc;
    logic [31:0]       r_crc;
    logic [63:0]       r_cur_off;
    logic [63:0]       r_page_start;
    logic [CNT_W-1:0]  r_page_cnt;
    logic [31:0]       r_delivered;
    logic [7:0]        r_bad_cnt;
    logic [1:0]        r_status;

    // Values of the state as seen by the current byte; a first byte of a
    // transaction sees a freshly opened page at the start offset.
    logic [2:0]        e_phase;
    logic [31:0]       e_exp_crc;
    logic [31:0]       e_crc;
    logic [63:0]       e_cur_off;
    logic [63:0]       e_page_start;
    logic [CNT_W-1:0]  e_page_cnt;
    logic [31:0]       e_delivered;
    logic [7:0]        e_bad_cnt;
    logic [1:0]        e_status;

    logic [2:0]        n_phase;
    logic [31:0]       n_exp_crc;
    logic [31:0]       n_crc;
    logic [63:0]       n_cur_off;
    logic [63:0]       n_page_start;
    logic [CNT_W-1:0]  n_page_cnt;
    logic [31:0]       n_delivered;
    logic [7:0]        n_bad_cnt;
    logic [1:0]        n_status;

    logic [31:0]       w_crc_upd;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [31:0]       w_cnt_ext;
    logic              w_at_boundary;
    logic              w_off_full;
    pcrc_pkg::t_out_item w_result;

    // Output side: result register plus one skid entry.
    logic                r_out_valid;
    pcrc_pkg::t_out_item r_out;
    logic                r_skid_valid;
    pcrc_pkg::t_out_item r_skid;

    logic w_in_xfer;
    logic w_out_free;

    assign o_in_stall  = r_skid_valid;
    assign w_in_xfer   = i_in_valid && !r_skid_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collect_mode <= 1'b0;
            r_capacity     <= pcrc_pkg::CAPACITY_RESET;
            r_bad_limit    <= pcrc_pkg::BAD_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcrc_pkg::CFG_COLLECT_MODE:    r_collect_mode <= i_cfg_data[0];
                pcrc_pkg::CFG_OUTPUT_CAPACITY: r_capacity     <= i_cfg_data;
                pcrc_pkg::CFG_BAD_PAGE_LIMIT:  r_bad_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // State seen by the byte: a new transaction opens its first page at the
    // start offset, and a negative start is malformed at once.
    always_comb begin
        if (r_in_txn) begin
            e_phase      = r_phase;
            e_exp_crc    = r_exp_crc;
            e_crc        = r_crc;
            e_cur_off    = r_cur_off;
            e_page_start = r_page_start;
            e_page_cnt   = r_page_cnt;
            e_delivered  = r_delivered;
            e_bad_cnt    = r_bad_cnt;
            e_status     = r_status;
        end else begin
            e_phase      = 3'd0;
            e_exp_crc    = 32'd0;
            e_crc        = pcrc_pkg::CRC_INIT;
            e_cur_off    = i_in_data.start_offset;
            e_page_start = i_in_data.start_offset;
            e_page_cnt   = '0;
            e_delivered  = 32'd0;
            e_bad_cnt    = 8'd0;
            e_status     = i_in_data.start_offset[63] ? pcrc_pkg::ST_MALFORMED
                                                      : pcrc_pkg::ST_OK;
        end
    end

    assign w_crc_upd = pcrc_pkg::crc32c_byte(e_crc, i_in_data.framed_byte);
    assign w_cnt_inc = e_page_cnt + CNT_W'(1);
    assign w_cnt_ext = 32'(w_cnt_inc);
    // The byte closes a page when the offset after it is a page multiple.
    assign w_at_boundary = &e_cur_off[PAGE_BITS-1:0];
    // One more byte would leave no room for a representable page end.
    assign w_off_full = e_cur_off[63] || (&e_cur_off[62:0]);

    // One step of the deframer for the byte at the input.
    always_comb begin
        n_phase      = e_phase;
        n_exp_crc    = e_exp_crc;
        n_crc        = e_crc;
        n_cur_off    = e_cur_off;
        n_page_start = e_page_start;
        n_page_cnt   = e_page_cnt;
        n_delivered  = e_delivered;
        n_bad_cnt    = e_bad_cnt;
        n_status     = e_status;

        w_result                    = '0;
        w_result.page_offset        = e_page_start;
        w_result.end_of_transaction = i_in_data.last;

        if (e_status == pcrc_pkg::ST_OK) begin
            if (e_phase < pcrc_pkg::CRC_BYTES) begin
                // Still collecting the page's CRC, most significant byte first.
                n_exp_crc = {e_exp_crc[23:0], i_in_data.framed_byte};
                n_phase   = e_phase + 3'd1;
                if (i_in_data.last) begin
                    n_status = pcrc_pkg::ST_MALFORMED;
                end
            end else if ((e_delivered == r_capacity) || w_off_full) begin
                n_status = pcrc_pkg::ST_MALFORMED;
            end else begin
                w_result.data_valid = 1'b1;
                w_result.data_byte  = i_in_data.framed_byte;
                n_crc       = w_crc_upd;
                n_page_cnt  = w_cnt_inc;
                n_cur_off   = e_cur_off + 64'd1;
                n_delivered = e_delivered + 32'd1;
                if (i_in_data.last || w_at_boundary) begin
                    w_result.page_done   = 1'b1;
                    w_result.page_length = w_cnt_ext[12:0];
                    if (~w_crc_upd != e_exp_crc) begin
                        w_result.page_bad = 1'b1;
                        if (!r_collect_mode) begin
                            n_status = pcrc_pkg::ST_CRC_FATAL;
                        end else if (e_bad_cnt >= r_bad_limit) begin
                            n_bad_cnt = r_bad_limit;
                            n_status  = pcrc_pkg::ST_TOO_MANY;
                        end else begin
                            n_bad_cnt = e_bad_cnt + 8'd1;
                        end
                    end
                    // Open the next page at the offset after this byte.
                    n_phase      = 3'd0;
                    n_exp_crc    = 32'd0;
                    n_crc        = pcrc_pkg::CRC_INIT;
                    n_page_cnt   = '0;
                    n_page_start = e_cur_off + 64'd1;
                end
            end
        end

        w_result.status          = n_status;
        w_result.bytes_delivered = n_delivered;
        w_result.bad_pages       = n_bad_cnt;
    end

    // State registers advance once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_txn     <= 1'b0;
            r_phase      <= 3'd0;
            r_exp_crc    <= 32'd0;
            r_crc        <= pcrc_pkg::CRC_INIT;
            r_cur_off    <= 64'd0;
            r_page_start <= 64'd0;
            r_page_cnt   <= '0;
            r_delivered  <= 32'd0;
            r_bad_cnt    <= 8'd0;
            r_status     <= pcrc_pkg::ST_OK;
        end else if (w_in_xfer) begin
            r_in_txn     <= !i_in_data.last;
            r_phase      <= n_phase;
            r_exp_crc    <= n_exp_crc;
            r_crc        <= n_crc;
            r_cur_off    <= n_cur_off;
            r_page_start <= n_page_start;
            r_page_cnt   <= n_page_cnt;
            r_delivered  <= n_delivered;
            r_bad_cnt    <= n_bad_cnt;
            r_status     <= n_status;
        end
    end

    // Result register with skid entry. A new result lands in the result
    // register when it is free, otherwise in the skid entry; the skid entry
    // moves forward as soon as the result register drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_xfer;
            end
        end else if (w_in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_xfer) begin
                r_out <= w_result;
            end
        end else if (w_in_xfer) begin
            r_skid <= w_result;
        end
    end

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while result register is empty");

    // CRC collection never runs past the four header bytes.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= pcrc_pkg::CRC_BYTES)
        else $error("CRC byte phase out of range");

    // A page never holds more data bytes than the page size.
    a_page_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_cnt <= CNT_W'(PAGE_SIZE))
        else $error("page byte count exceeds page size");

    // Page data is counted only while the CRC header is complete.
    a_cnt_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_page_cnt != '0) |-> (r_phase == pcrc_pkg::CRC_BYTES))
        else $error("page data counted before its CRC header");

    // A transfer that meets a full skid entry is impossible.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_out_free) |=> r_skid_valid && $stable(r_skid))
        else $error("held result in skid entry was lost");
`endif

endmodule
